// ===== rtl/core/segment_triangle_intersect_top_macros.svh =====
// Assertion macros for the segment versus triangle intersection block.
// Included by the top level; has no dependencies of its own.
`ifndef SEGMENT_TRIANGLE_INTERSECT_TOP_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define STI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define STI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define STI_ASSERT_NOW(label, clk, rst, ante, cons)
`define STI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/sti_pkg.sv =====
// Shared types and constants of the segment versus triangle intersection block.
// No dependencies; imported by the interfaces, the divider and the top level.
`default_nettype none
package sti_pkg;
  localparam int FIELD_W    = 63;
  localparam int FRAC_OUT_W = 16;

  typedef struct packed {
    logic               hit;
    logic               toward;
    logic [2:0]         dneg;
    logic [FIELD_W-1:0] start;
  } sti_side_t;
endpackage
`default_nettype wire

// ===== rtl/core/sti_if.sv =====
// Valid/ready channels of the intersection block: one for test beats, one for results.
// Depends on sti_pkg.
`default_nettype none
interface sti_item_if import sti_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] segment_start;
  logic [FIELD_W-1:0] segment_direction;
  logic [FIELD_W-1:0] triangle_origin;
  logic [FIELD_W-1:0] triangle_edge_a;
  logic [FIELD_W-1:0] triangle_edge_b;

  modport source (output valid, segment_start, segment_direction, triangle_origin,
                  triangle_edge_a, triangle_edge_b, input ready);
  modport sink (input valid, segment_start, segment_direction, triangle_origin,
                triangle_edge_a, triangle_edge_b, output ready);
endinterface

interface sti_result_if import sti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FIELD_W-1:0]    hit_position;
  logic [FRAC_OUT_W-1:0] segment_fraction;
  logic                  toward_normal;

  modport source (output valid, hit, hit_position, segment_fraction, toward_normal,
                  input ready);
  modport sink (input valid, hit, hit_position, segment_fraction, toward_normal,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sti_div.sv =====
// Pipelined restoring divider: the Q0.16 fraction and the three position offsets,
// one quotient digit per stage. Depends on sti_pkg.
`default_nettype none
module sti_div import sti_pkg::*; #(
  parameter int COMPONENT_WIDTH = 21,
  localparam int CW = COMPONENT_WIDTH,
  localparam int AW = 3 * CW + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [AW-1:0]     a,
  input  logic [AW-1:0]     b,
  input  logic [3*CW-1:0]   m,
  input  sti_side_t         side_in,
  output logic              out_valid,
  output logic [3*CW-1:0]   quo,
  output logic [2:0]        rnz,
  output logic [FRAC_OUT_W-1:0] frac,
  output sti_side_t         side_out
);
  localparam int DS = (CW > FRAC_OUT_W) ? CW : FRAC_OUT_W;

  logic [DS-1:0]         v;
  logic [AW-1:0]         ra [DS];
  logic [AW-1:0]         rb [DS];
  logic [AW-1:0]         rf [DS];
  logic [FRAC_OUT_W-1:0] rq [DS];
  logic [3*CW-1:0]       rm [DS];
  logic [3*CW-1:0]       pq [DS];
  logic [AW-1:0]         pr [DS][3];
  sti_side_t             rs [DS];

  logic [AW-1:0]         fn  [DS];
  logic [FRAC_OUT_W-1:0] qn  [DS];
  logic [3*CW-1:0]       pqn [DS];
  logic [AW-1:0]         prn [DS][3];

  for (genvar k = 0; k < DS; k++) begin : g_stage
    logic [AW-1:0]         a_i;
    logic [AW-1:0]         b_i;
    logic [AW-1:0]         f_i;
    logic [FRAC_OUT_W-1:0] q_i;
    logic [3*CW-1:0]       m_i;
    logic [3*CW-1:0]       pq_i;
    logic [AW-1:0]         pr_i [3];

    if (k == 0) begin : g_head
      assign a_i  = a;
      assign b_i  = b;
      assign f_i  = a;
      assign q_i  = '0;
      assign m_i  = m;
      assign pq_i = '0;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign pr_i[c] = '0;
      end
    end else begin : g_tail
      assign a_i  = ra[k-1];
      assign b_i  = rb[k-1];
      assign f_i  = rf[k-1];
      assign q_i  = rq[k-1];
      assign m_i  = rm[k-1];
      assign pq_i = pq[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign pr_i[c] = pr[k-1][c];
      end
    end

    if (k < FRAC_OUT_W) begin : g_frac
      logic [AW:0] f2;
      logic        ge;
      assign f2    = {f_i, 1'b0};
      assign ge    = f2 >= {1'b0, b_i};
      assign fn[k] = ge ? AW'(f2 - {1'b0, b_i}) : AW'(f2);
      assign qn[k] = {q_i[FRAC_OUT_W-2:0], ge};
    end else begin : g_frac_pass
      assign fn[k] = f_i;
      assign qn[k] = q_i;
    end

    if (k >= DS - CW) begin : g_pos
      localparam int BI = DS - 1 - k;
      logic [3*CW-1:0] pq_w;
      logic [AW-1:0]   pr_w [3];
      always_comb begin
        logic [AW+1:0] r2;
        logic [AW+1:0] b1;
        logic [AW+1:0] b2;
        logic [1:0]    dig;
        b1 = {2'b00, b_i};
        b2 = {1'b0, b_i, 1'b0};
        for (int c = 0; c < 3; c++) begin
          r2 = {1'b0, pr_i[c], 1'b0} + (m_i[c*CW+BI] ? {2'b00, a_i} : '0);
          priority if (r2 >= b2) begin
            pr_w[c] = AW'(r2 - b2);
            dig     = 2'd2;
          end else if (r2 >= b1) begin
            pr_w[c] = AW'(r2 - b1);
            dig     = 2'd1;
          end else begin
            pr_w[c] = AW'(r2);
            dig     = 2'd0;
          end
          pq_w[c*CW +: CW] = CW'({pq_i[c*CW +: CW], 1'b0} + {{(CW-1){1'b0}}, dig});
        end
      end
      assign pqn[k] = pq_w;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign prn[k][c] = pr_w[c];
      end
    end else begin : g_pos_pass
      assign pqn[k] = pq_i;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign prn[k][c] = pr_i[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra[0] <= a;
      rb[0] <= b;
      rm[0] <= m;
      rs[0] <= side_in;
      for (int k = 1; k < DS; k++) begin
        ra[k] <= ra[k-1];
        rb[k] <= rb[k-1];
        rm[k] <= rm[k-1];
        rs[k] <= rs[k-1];
      end
      for (int k = 0; k < DS; k++) begin
        rf[k] <= fn[k];
        rq[k] <= qn[k];
        pq[k] <= pqn[k];
        for (int c = 0; c < 3; c++) begin
          pr[k][c] <= prn[k][c];
        end
      end
    end
  end

  assign out_valid = v[DS-1];
  assign quo       = pq[DS-1];
  assign frac      = rq[DS-1];
  assign side_out  = rs[DS-1];
  for (genvar c = 0; c < 3; c++) begin : g_rnz
    assign rnz[c] = |pr[DS-1][c];
  end
endmodule
`default_nettype wire

// ===== rtl/core/segment_triangle_intersect_top.sv =====
// Segment versus triangle intersection: exact integer plane and edge tests,
// then the crossing fraction and point. Accepts one beat every clock cycle
// while no result is stalled; the front stages feed a divider that produces
// one quotient digit per stage, and the result is registered after it.
// A stalled result holds the whole pipeline.
// Depends on sti_pkg, sti_if, sti_div and the assertion macro header.
`default_nettype none
`include "segment_triangle_intersect_top_macros.svh"
module segment_triangle_intersect_top import sti_pkg::*; #(
  parameter int COMPONENT_WIDTH = 21
) (
  input  logic          clk,
  input  logic          rst,
  sti_item_if.sink      item,
  sti_result_if.source  result
);
  localparam int CW    = COMPONENT_WIDTH;
  localparam int SOW   = CW + 1;
  localparam int Q2W   = CW + 2;
  localparam int NW    = 2 * CW + 1;
  localparam int CXW   = 2 * CW + 4;
  localparam int NLO   = NW / 2;
  localparam int CLO   = CXW / 2;
  localparam int PW    = 2 * CW + 3;
  localparam int EW    = 3 * CW + 6;
  localparam int AW    = 3 * CW + 3;
  localparam int FRONT = 7;
  localparam int NX1 [3] = '{1, 2, 0};
  localparam int NX2 [3] = '{2, 0, 1};
  localparam logic signed [CW+1:0] PMAX = (CW+2)'((1 << (CW - 1)) - 1);
  localparam logic signed [CW+1:0] PMIN = -PMAX - 1;

  logic                   en;
  logic [FRONT-1:0]       vp;
  logic signed [CW-1:0]   us [3];
  logic signed [CW-1:0]   ud [3];
  logic signed [CW-1:0]   uo [3];
  logic signed [CW-1:0]   ue0 [3];
  logic signed [CW-1:0]   ue1 [3];

  logic [FIELD_W-1:0]     st [FRONT-1];
  logic signed [CW-1:0]   dd [FRONT-1][3];
  logic signed [SOW-1:0]  s1_so [3];
  logic signed [SOW-1:0]  s1_q [3];
  logic signed [Q2W-1:0]  s1_q2 [3];
  logic signed [SOW-1:0]  s1_f [3];
  logic signed [CW-1:0]   s1_e0 [3];
  logic signed [CW-1:0]   s1_e1 [3];
  logic signed [SOW-1:0]  s2_so [3];
  logic signed [2*CW-1:0] s2_np [3];
  logic signed [2*CW-1:0] s2_nm [3];
  logic signed [2*CW:0]   s2_ap [3];
  logic signed [2*CW:0]   s2_am [3];
  logic signed [2*CW:0]   s2_bp [3];
  logic signed [2*CW:0]   s2_bm [3];
  logic signed [2*CW+2:0] s2_cp [3];
  logic signed [2*CW+2:0] s2_cm [3];
  logic signed [SOW-1:0]  s3_so [3];
  logic signed [NW-1:0]   s3_n [3];
  logic signed [CXW-1:0]  s3_cx [3][3];
  logic signed [PW-1:0]   s4_p0h [3];
  logic signed [PW-1:0]   s4_p0l [3];
  logic signed [PW-1:0]   s4_pdh [3];
  logic signed [PW-1:0]   s4_pdl [3];
  logic signed [PW-1:0]   s4_ph [3][3];
  logic signed [PW-1:0]   s4_pl [3][3];
  logic signed [EW-1:0]   s5_d0c [3];
  logic signed [EW-1:0]   s5_dnc [3];
  logic signed [EW-1:0]   s5_ec [3][3];
  logic signed [EW-1:0]   s6_d0;
  logic signed [EW-1:0]   s6_dn;
  logic signed [EW-1:0]   s6_e [3];
  logic [AW-1:0]          s7_a;
  logic [AW-1:0]          s7_b;
  logic [3*CW-1:0]        s7_m;
  sti_side_t              s7_side;

  logic [AW-1:0]          a_n;
  logic [AW-1:0]          b_n;
  logic [3*CW-1:0]        m_n;
  sti_side_t              side_n;

  logic                   dv;
  logic [3*CW-1:0]        dq;
  logic [2:0]             drnz;
  logic [FRAC_OUT_W-1:0]  dfrac;
  sti_side_t              dside;
  logic [3*CW-1:0]        pos_n;

  assign en         = !result.valid || result.ready;
  assign item.ready = en;

  for (genvar c = 0; c < 3; c++) begin : g_unpack
    assign us[c]  = $signed(item.segment_start[c*CW +: CW]);
    assign ud[c]  = $signed(item.segment_direction[c*CW +: CW]);
    assign uo[c]  = $signed(item.triangle_origin[c*CW +: CW]);
    assign ue0[c] = $signed(item.triangle_edge_a[c*CW +: CW]);
    assign ue1[c] = $signed(item.triangle_edge_b[c*CW +: CW]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[FRONT-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= item.segment_start;
      for (int k = 1; k < FRONT - 1; k++) begin
        st[k] <= st[k-1];
        for (int c = 0; c < 3; c++) begin
          dd[k][c] <= dd[k-1][c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        dd[0][c] <= ud[c];
        s1_so[c] <= SOW'(us[c]) - SOW'(uo[c]);
        s1_q[c]  <= SOW'(uo[c]) - SOW'(us[c]);
        s1_q2[c] <= Q2W'(uo[c]) + Q2W'(ue0[c]) - Q2W'(us[c]);
        s1_f[c]  <= SOW'(ue1[c]) - SOW'(ue0[c]);
        s1_e0[c] <= ue0[c];
        s1_e1[c] <= ue1[c];

        s2_so[c] <= s1_so[c];
        s2_np[c] <= s1_e0[NX1[c]] * s1_e1[NX2[c]];
        s2_nm[c] <= s1_e0[NX2[c]] * s1_e1[NX1[c]];
        s2_ap[c] <= s1_q[NX1[c]] * s1_e0[NX2[c]];
        s2_am[c] <= s1_q[NX2[c]] * s1_e0[NX1[c]];
        s2_bp[c] <= s1_q[NX1[c]] * s1_e1[NX2[c]];
        s2_bm[c] <= s1_q[NX2[c]] * s1_e1[NX1[c]];
        s2_cp[c] <= s1_q2[NX1[c]] * s1_f[NX2[c]];
        s2_cm[c] <= s1_q2[NX2[c]] * s1_f[NX1[c]];

        s3_so[c]    <= s2_so[c];
        s3_n[c]     <= NW'(s2_np[c]) - NW'(s2_nm[c]);
        s3_cx[0][c] <= CXW'(s2_ap[c]) - CXW'(s2_am[c]);
        s3_cx[1][c] <= CXW'(s2_bp[c]) - CXW'(s2_bm[c]);
        s3_cx[2][c] <= CXW'(s2_cp[c]) - CXW'(s2_cm[c]);

        s4_p0h[c] <= $signed(s3_n[c][NW-1:NLO]) * s3_so[c];
        s4_p0l[c] <= $signed({1'b0, s3_n[c][NLO-1:0]}) * s3_so[c];
        s4_pdh[c] <= $signed(s3_n[c][NW-1:NLO]) * dd[2][c];
        s4_pdl[c] <= $signed({1'b0, s3_n[c][NLO-1:0]}) * dd[2][c];
        for (int j = 0; j < 3; j++) begin
          s4_ph[j][c] <= $signed(s3_cx[j][c][CXW-1:CLO]) * dd[2][c];
          s4_pl[j][c] <= $signed({1'b0, s3_cx[j][c][CLO-1:0]}) * dd[2][c];
          s5_ec[j][c] <= (EW'(s4_ph[j][c]) <<< CLO) + EW'(s4_pl[j][c]);
        end
        s5_d0c[c] <= (EW'(s4_p0h[c]) <<< NLO) + EW'(s4_p0l[c]);
        s5_dnc[c] <= (EW'(s4_pdh[c]) <<< NLO) + EW'(s4_pdl[c]);
      end
      s6_d0 <= s5_d0c[0] + s5_d0c[1] + s5_d0c[2];
      s6_dn <= s5_dnc[0] + s5_dnc[1] + s5_dnc[2];
      for (int j = 0; j < 3; j++) begin
        s6_e[j] <= s5_ec[j][0] + s5_ec[j][1] + s5_ec[j][2];
      end
      s7_a    <= a_n;
      s7_b    <= b_n;
      s7_m    <= m_n;
      s7_side <= side_n;
    end
  end

  // A point on an edge plane gives a zero triple product and counts as inside.
  always_comb begin
    logic signed [EW-1:0] d1;
    logic                 dn_neg;
    logic                 miss;
    d1     = s6_d0 + s6_dn;
    dn_neg = s6_dn[EW-1];
    miss   = ((s6_e[0] != '0) && (s6_e[0][EW-1] != dn_neg)) ||
             ((s6_e[1] != '0) && (s6_e[1][EW-1] == dn_neg)) ||
             ((s6_e[2] != '0) && (s6_e[2][EW-1] != dn_neg));
    side_n.hit    = (s6_d0 != '0) && (d1 != '0) && (s6_d0[EW-1] != d1[EW-1]) &&
                    (s6_dn != '0) && !miss;
    side_n.toward = s6_d0[EW-1];
    side_n.start  = st[FRONT-2];
    a_n = s6_d0[EW-1] ? AW'(-s6_d0) : AW'(s6_d0);
    b_n = dn_neg ? AW'(-s6_dn) : AW'(s6_dn);
    for (int c = 0; c < 3; c++) begin
      side_n.dneg[c]   = dd[FRONT-2][c][CW-1];
      m_n[c*CW +: CW]  = dd[FRONT-2][c][CW-1] ? $unsigned(-dd[FRONT-2][c])
                                              : $unsigned(dd[FRONT-2][c]);
    end
  end

  sti_div #(
    .COMPONENT_WIDTH(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vp[FRONT-1]),
    .a        (s7_a),
    .b        (s7_b),
    .m        (s7_m),
    .side_in  (s7_side),
    .out_valid(dv),
    .quo      (dq),
    .rnz      (drnz),
    .frac     (dfrac),
    .side_out (dside)
  );

  // Negative direction components take the floor, so a nonzero remainder adds one.
  always_comb begin
    logic signed [CW+1:0] qe;
    logic signed [CW+1:0] off;
    logic signed [CW+1:0] p;
    pos_n = '0;
    for (int c = 0; c < 3; c++) begin
      qe  = $signed({2'b00, dq[c*CW +: CW]});
      off = dside.dneg[c] ? -(qe + $signed({{(CW+1){1'b0}}, drnz[c]})) : qe;
      p   = $signed((CW+2)'($signed(dside.start[c*CW +: CW]))) + off;
      priority if (p > PMAX) begin
        pos_n[c*CW +: CW] = PMAX[CW-1:0];
      end else if (p < PMIN) begin
        pos_n[c*CW +: CW] = PMIN[CW-1:0];
      end else begin
        pos_n[c*CW +: CW] = p[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.hit              <= dside.hit;
      result.hit_position     <= dside.hit ? FIELD_W'(pos_n) : '0;
      result.segment_fraction <= dside.hit ? dfrac : '0;
      result.toward_normal    <= dside.hit && dside.toward;
    end
  end

  `STI_ASSERT_NOW(a_miss_is_zero, clk, rst, result.valid && !result.hit, result.hit_position == '0 && result.segment_fraction == '0 && !result.toward_normal)
  `STI_ASSERT_NOW(a_stall_holds_input, clk, rst, result.valid && !result.ready, !item.ready)
  `STI_ASSERT_NEXT(a_accept_enters, clk, rst, item.valid && item.ready, vp[0])
endmodule
`default_nettype wire

// ===== tb/segment_triangle_intersect_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the segment versus triangle intersection block.
// Depends on sti_pkg, the channel interfaces in sti_if and segment_triangle_intersect_top.
module segment_triangle_intersect_top_tb;
  import sti_pkg::*;

  localparam int CW = 21;
  localparam int RESULT_LATENCY = 8 + CW;

  typedef longint vec3_t[3];
  typedef struct {
    bit                  hit;
    bit [FIELD_W-1:0]    position;
    bit [FRAC_OUT_W-1:0] fraction;
    bit                  toward;
  } crossing_t;

  logic clk;
  logic rst;

  sti_item_if   item_ch();
  sti_result_if result_ch();

  segment_triangle_intersect_top #(.COMPONENT_WIDTH(CW)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  crossing_t pending_crossings[$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        hits_sent = 0;
  int        results_seen = 0;
  int        burst_left = 0;
  bit        hold_request = 0;
  int        hold_count = 0;
  int        stall_mode = 0;
  int        mode_left = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic vec3_t unpack3(bit [FIELD_W-1:0] w);
    vec3_t v;
    logic signed [CW-1:0] comp;
    for (int c = 0; c < 3; c++) begin
      comp = w[c*CW +: CW];
      v[c] = comp;
    end
    return v;
  endfunction

  function automatic bit [FIELD_W-1:0] pack3(longint x, longint y, longint z);
    bit [FIELD_W-1:0] w;
    w[0 +: CW]    = x[CW-1:0];
    w[CW +: CW]   = y[CW-1:0];
    w[2*CW +: CW] = z[CW-1:0];
    return w;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic signed [127:0] dot3(vec3_t a, vec3_t b);
    logic signed [127:0] sum, x, y;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      x = a[c];
      y = b[c];
      sum += x * y;
    end
    return sum;
  endfunction

  function automatic int sign_of(logic signed [127:0] v);
    return (v < 0) ? -1 : ((v != 0) ? 1 : 0);
  endfunction

  function automatic crossing_t predict_crossing(bit [FIELD_W-1:0] fs, bit [FIELD_W-1:0] fd,
      bit [FIELD_W-1:0] fo, bit [FIELD_W-1:0] fa, bit [FIELD_W-1:0] fb);
    crossing_t r;
    vec3_t s, d, o, e0, e1, n, so, se, q, q2, f;
    logic signed [127:0] d0, d1, dn;
    logic [127:0] num_abs, den_abs, scaled, quot, remd, dmag;
    longint off, p, lim;
    int sg0, sg1, sdn;
    r = '{default: 0};
    lim = longint'(1) << (CW - 1);
    s = unpack3(fs); d = unpack3(fd); o = unpack3(fo);
    e0 = unpack3(fa); e1 = unpack3(fb);
    n = cross3(e0, e1);
    for (int c = 0; c < 3; c++) begin
      so[c] = s[c] - o[c];
      se[c] = s[c] + d[c] - o[c];
      q[c]  = o[c] - s[c];
      q2[c] = o[c] + e0[c] - s[c];
      f[c]  = e1[c] - e0[c];
    end
    d0 = dot3(n, so);
    d1 = dot3(n, se);
    dn = dot3(n, d);
    sg0 = sign_of(d0);
    sg1 = sign_of(d1);
    sdn = sign_of(dn);
    if (sg0 == 0 || sg1 == 0 || sg0 == sg1 || sdn == 0) return r;
    if (sign_of(dot3(d, cross3(q, e0))) * sdn < 0) return r;
    if (sign_of(dot3(d, cross3(q, e1))) * sdn > 0) return r;
    if (sign_of(dot3(d, cross3(q2, f))) * sdn < 0) return r;
    num_abs = (sg0 < 0) ? -d0 : d0;
    den_abs = (sdn < 0) ? -dn : dn;
    scaled = (num_abs << FRAC_OUT_W) / den_abs;
    r.fraction = scaled[FRAC_OUT_W-1:0];
    for (int c = 0; c < 3; c++) begin
      dmag = (d[c] < 0) ? -d[c] : d[c];
      quot = (num_abs * dmag) / den_abs;
      remd = (num_abs * dmag) % den_abs;
      off = quot[63:0];
      if (d[c] < 0) off = -(off + ((remd != 0) ? 1 : 0));
      p = s[c] + off;
      if (p < -lim) p = -lim;
      if (p > lim - 1) p = lim - 1;
      r.position[c*CW +: CW] = p[CW-1:0];
    end
    r.hit = 1;
    r.toward = (sg0 < 0);
    return r;
  endfunction

  task automatic send_beat(bit [FIELD_W-1:0] fs, bit [FIELD_W-1:0] fd, bit [FIELD_W-1:0] fo,
      bit [FIELD_W-1:0] fa, bit [FIELD_W-1:0] fb);
    crossing_t expected;
    int gap;
    item_ch.valid             <= 1'b1;
    item_ch.segment_start     <= fs;
    item_ch.segment_direction <= fd;
    item_ch.triangle_origin   <= fo;
    item_ch.triangle_edge_a   <= fa;
    item_ch.triangle_edge_b   <= fb;
    do @(posedge clk); while (!item_ch.ready);
    expected = predict_crossing(fs, fd, fo, fa, fb);
    pending_crossings.push_back(expected);
    beats_sent++;
    if (expected.hit) hits_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    crossing_t exp_c;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pending_crossings.size() == 0) begin
        $error("unexpected result beat");
        mismatches++;
      end else begin
        exp_c = pending_crossings.pop_front();
        if (result_ch.hit !== exp_c.hit) begin
          $error("hit: expected %0d actual %0d", exp_c.hit, result_ch.hit);
          mismatches++;
        end
        if (result_ch.hit_position !== exp_c.position) begin
          $error("hit_position: expected %h actual %h", exp_c.position, result_ch.hit_position);
          mismatches++;
        end
        if (result_ch.segment_fraction !== exp_c.fraction) begin
          $error("segment_fraction: expected %h actual %h", exp_c.fraction,
                 result_ch.segment_fraction);
          mismatches++;
        end
        if (result_ch.toward_normal !== exp_c.toward) begin
          $error("toward_normal: expected %0d actual %0d", exp_c.toward,
                 result_ch.toward_normal);
          mismatches++;
        end
      end
    end
    if (hold_request && hold_count < 300) begin
      hold_count++;
      result_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= ($urandom_range(0, 1) == 1);
        default: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic longint spread(longint m);
    return longint'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic bit [FIELD_W-1:0] any_field();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  task automatic test_directed();
    bit [FIELD_W-1:0] o, ea, eb;
    o  = pack3(0, 0, 0);
    ea = pack3(4096, 0, 0);
    eb = pack3(0, 4096, 0);
    send_beat(pack3(1024, 1024, -1024), pack3(0, 0, 2048), o, ea, eb);
    send_beat(pack3(1024, 1024, 1024), pack3(0, 0, -2048), o, ea, eb);
    send_beat(pack3(1024, 1024, 0), pack3(0, 0, 2048), o, ea, eb);
    send_beat(pack3(1024, 1024, -1024), pack3(0, 0, 1024), o, ea, eb);
    send_beat(pack3(1024, 1024, -1024), pack3(0, 0, 2048), o, ea, ea);
    send_beat(pack3(2048, 0, -1024), pack3(0, 0, 2048), o, ea, eb);
    send_beat(pack3(0, 0, -1), pack3(0, 0, 3), o, ea, eb);
    send_beat(pack3(2048, 2048, -5), pack3(0, 0, 9), o, ea, eb);
    send_beat(pack3(3000, 3000, -5), pack3(0, 0, 9), o, ea, eb);
    send_beat(pack3(-1, 1, -1024), pack3(0, 0, 2048), o, ea, eb);
    send_beat(pack3(1000, 1000, -3), pack3(-7, 5, 10), o, ea, eb);
    send_beat(pack3(1000, 1000, 7), pack3(13, -11, -10), o, ea, eb);
    send_beat(pack3(1000, 1000, -1), pack3(0, 0, 3), o, ea, eb);
    send_beat(pack3(1048575, 10, -5), pack3(100, 0, 10), pack3(1040000, 0, 0),
              pack3(20000, 0, 0), pack3(0, 20000, 0));
    send_beat(pack3(-1048576, -10, -5), pack3(-100, 0, 10), pack3(-1040000, 0, 0),
              pack3(-20000, 0, 0), pack3(0, -20000, 0));
    send_beat('0, '0, '0, '0, '0);
    send_beat('1, '1, '1, '1, '1);
    send_beat(pack3(1048575, 1048575, 1048575), pack3(-1048576, -1048576, -1048576),
              pack3(-1048576, 1048575, -1048576), pack3(1048575, -1048576, 1048575),
              pack3(-1048576, 1048575, 1048575));
    send_beat(pack3(-1048576, -1048576, -1048576), pack3(1048575, 1048575, 1048575),
              pack3(0, 0, 0), pack3(1048575, 0, 0), pack3(0, 1048575, 0));
    send_beat(pack3(-100, -100, -1048576), pack3(0, 0, 1048575), pack3(-1048576, -1048576, 0),
              pack3(1048575, 0, 0), pack3(0, 1048575, 0));
  endtask

  task automatic send_crossing_segment(longint span);
    vec3_t o, ea, eb, d, s;
    longint u, v, k;
    u = $urandom_range(0, 256);
    v = $urandom_range(0, 256 - u);
    if ($urandom_range(0, 7) == 0) v = 0;
    k = $urandom_range(1, 255);
    for (int c = 0; c < 3; c++) begin
      o[c]  = spread(span * 2);
      ea[c] = spread(span);
      eb[c] = spread(span);
      d[c]  = spread(span);
      s[c]  = o[c] + (u * ea[c] + v * eb[c]) / 256 - (d[c] * k) / 256;
    end
    send_beat(pack3(s[0], s[1], s[2]), pack3(d[0], d[1], d[2]), pack3(o[0], o[1], o[2]),
              pack3(ea[0], ea[1], ea[2]), pack3(eb[0], eb[1], eb[2]));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    send_beat(any_field(), any_field(), any_field(), any_field(), any_field());
        2:       send_crossing_segment(8);
        3:       send_crossing_segment(1 << 19);
        default: send_crossing_segment(1 << 16);
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_request = 1;
    for (int i = 0; i < 80; i++) send_crossing_segment(1 << 12);
    hold_request = 0;
  endtask

  initial begin
    #2000000;
    $display("segment_triangle_intersect_top test failed");
    $finish;
  end

  initial begin
    int waited;
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.segment_start <= '0;
    item_ch.segment_direction <= '0;
    item_ch.triangle_origin <= '0;
    item_ch.triangle_edge_a <= '0;
    item_ch.triangle_edge_b <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_random(320);
    item_ch.valid <= 1'b0;
    waited = 0;
    while (pending_crossings.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (RESULT_LATENCY + 10) @(posedge clk);
    $display("Sent %0d beats (%0d crossings), checked %0d results under random stalls.",
             beats_sent, hits_sent, results_seen);
    if (mismatches == 0 && pending_crossings.size() == 0) begin
      $display("segment_triangle_intersect_top test passed");
    end else begin
      $display("segment_triangle_intersect_top test failed");
    end
    $finish;
  end
endmodule
